// ----- src/i2dt_pkg.sv -----
// Shared types and constants for the decimal text formatter.
package i2dt_pkg;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_MINUS = 8'd45;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic shift;
      logic find;
      logic emit_sign;
      logic emit_digit;
   } i2dt_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic negative;
      logic ptr_zero;
      logic out_free;
   } i2dt_status_type;

endpackage

// ----- src/i2dt_if.sv -----
// Valid/ready channel interfaces for the value input and the character output.
interface i2dt_req_if #(
   parameter int VALUE_BITS = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface i2dt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

// ----- src/i2dt_ctrl.sv -----
// Sequencer for the formatter: conversion bit count and character emission.
module i2dt_ctrl #(
   parameter int VALUE_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  i2dt_pkg::i2dt_status_type status,
   output i2dt_pkg::i2dt_cmd_type    cmd
);
   import i2dt_pkg::*;

   localparam int CNT_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_FIND,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   state_type           state_ff;
   logic [CNT_BITS-1:0] cnt_ff;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:  cmd.load       = req_valid;
         ST_CONV:  cmd.shift      = 1'b1;
         ST_FIND:  cmd.find       = 1'b1;
         ST_SIGN:  cmd.emit_sign  = status.out_free;
         ST_DIGIT: cmd.emit_digit = status.out_free;
         default:  cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (req_valid) begin
                  state_ff <= ST_CONV;
               end
            end
            ST_CONV: begin
               cnt_ff <= cnt_ff + CNT_BITS'(1);
               if (cnt_ff == CNT_BITS'(VALUE_BITS - 1)) begin
                  state_ff <= ST_FIND;
               end
            end
            ST_FIND: begin
               state_ff <= status.negative ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN: begin
               if (status.out_free) begin
                  state_ff <= ST_DIGIT;
               end
            end
            ST_DIGIT: begin
               if (status.out_free && status.ptr_zero) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ----- src/i2dt_datapath.sv -----
// Magnitude, shift-add-3 BCD converter, digit pointer and output register.
module i2dt_datapath #(
   parameter int VALUE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic signed [VALUE_BITS-1:0] req_value,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [7:0]                   rsp_character,
   output logic                         rsp_last,
   input  i2dt_pkg::i2dt_cmd_type        cmd,
   output i2dt_pkg::i2dt_status_type     status
);
   import i2dt_pkg::*;

   // digits of 2^VALUE_BITS, enough for any magnitude
   localparam int DIGITS   = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int BCD_BITS = DIGITS * 4;
   localparam int PTR_BITS = $clog2(DIGITS);

   logic                  neg_ff;
   logic [VALUE_BITS-1:0] bin_ff;
   logic [BCD_BITS-1:0]   bcd_ff;
   logic [PTR_BITS-1:0]   ptr_ff;
   logic                  rsp_valid_ff;
   logic [7:0]            char_ff;
   logic                  last_ff;

   logic [BCD_BITS-1:0]   adj_w;
   logic [3:0]            digit_w [DIGITS];
   logic [PTR_BITS-1:0]   lead_w;
   logic [VALUE_BITS-1:0] mag_w;

   assign mag_w = req_value[VALUE_BITS-1] ? (~req_value + VALUE_BITS'(1)) : req_value;

   always_comb begin
      lead_w = '0;
      for (int i = 0; i < DIGITS; i++) begin
         digit_w[i]      = bcd_ff[4*i +: 4];
         adj_w[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? (bcd_ff[4*i +: 4] + 4'd3)
                                                       : bcd_ff[4*i +: 4];
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            lead_w = PTR_BITS'(i);
         end
      end
   end

   assign status.negative = neg_ff;
   assign status.ptr_zero = (ptr_ff == '0);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff <= req_value[VALUE_BITS-1];
         bin_ff <= mag_w;
         bcd_ff <= '0;
      end else if (cmd.shift) begin
         bin_ff <= {bin_ff[VALUE_BITS-2:0], 1'b0};
         bcd_ff <= {adj_w[BCD_BITS-2:0], bin_ff[VALUE_BITS-1]};
      end
      if (cmd.find) begin
         ptr_ff <= lead_w;
      end else if (cmd.emit_digit) begin
         ptr_ff <= ptr_ff - PTR_BITS'(1);
      end
      if (cmd.emit_sign) begin
         char_ff <= CHAR_MINUS;
         last_ff <= 1'b0;
      end else if (cmd.emit_digit) begin
         char_ff <= CHAR_ZERO + {4'd0, digit_w[ptr_ff]};
         last_ff <= (ptr_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_sign || cmd.emit_digit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule

// ----- src/integer_to_decimal_text.sv -----
// Signed integer to decimal ASCII text, most significant character first.
// The first character follows the input transfer once the shift-add-3 converter has taken
// in the magnitude bit by bit and the lead digit has been located.
// Throughput: one item at a time, a new value being accepted only after the last character
// of the previous one is emitted; one character per cycle when the output is not stalled.
// Reset (synchronous, active high) returns the sequencer to idle and empties the output.
module integer_to_decimal_text #(
   parameter int VALUE_BITS = 32
) (
   input logic            clock,
   input logic            reset,
   i2dt_req_if.sink       req_if,
   i2dt_rsp_if.source     rsp_if
);
   import i2dt_pkg::*;

   i2dt_cmd_type    cmd;
   i2dt_status_type status;

   i2dt_ctrl #(
      .VALUE_BITS(VALUE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   i2dt_datapath #(
      .VALUE_BITS(VALUE_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_if.value),
      .rsp_ready     (rsp_if.ready),
      .rsp_valid     (rsp_if.valid),
      .rsp_character (rsp_if.character),
      .rsp_last      (rsp_if.last),
      .cmd           (cmd),
      .status        (status)
   );

endmodule
